>>> rtl/egbw_pkg.sv
package egbw_pkg;

	localparam int MaxRawBitsDefault = 64;
	localparam int CmdFifoDepth      = 4;

	localparam int ValueW = 64;
	localparam int LenW   = 7;
	localparam int AccW   = ValueW + 8;
	localparam int NbW    = 4;

	localparam logic [31:0]       START_CODE = 32'h0000_0001;
	localparam logic [ValueW-1:0] UE_MAX     = 64'd4294967294;
	localparam logic [LenW-1:0]   NAL_HDR_LEN = 7'd40;

	typedef enum logic [2:0] {
		ACT_RAW       = 3'd0,
		ACT_UE        = 3'd1,
		ACT_SE        = 3'd2,
		ACT_NAL_START = 3'd3,
		ACT_NAL_END   = 3'd4,
		ACT_FLUSH     = 3'd5
	} action_t;

	// Normalized write command: data is left aligned, len bits long, and
	// pad asks for zero bits up to the next byte boundary afterward.
	typedef struct packed {
		logic [ValueW-1:0] data;
		logic [LenW-1:0]   len;
		logic              pad;
	} cmd_t;

endpackage

>>> rtl/egbw_front.sv
module egbw_front #(
	parameter int MAX_RAW_BITS = egbw_pkg::MaxRawBitsDefault
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  logic [2:0]          action,
	input  logic [6:0]          bit_count,
	input  logic [63:0]         value,
	input  logic signed [30:0]  signed_value,
	input  logic [4:0]          nal_type,
	input  logic [1:0]          ref_idc,
	output logic                cmd_push,
	output egbw_pkg::cmd_t      cmd,
	input  logic                cmd_full
);
	import egbw_pkg::*;

	localparam logic [LenW-1:0] MaxLen = LenW'(MAX_RAW_BITS);

	logic              valid_s1;
	logic              is_ue_s1;
	logic [ValueW-1:0] data_s1;
	logic [LenW-1:0]   len_s1;
	logic              pad_s1;

	logic              advance;
	logic              accept;
	logic              keep;
	logic              is_ue;
	logic [ValueW-1:0] data;
	logic [LenW-1:0]   len;
	logic              pad;
	logic [31:0]       sv_ext;
	logic [31:0]       sv_neg;
	logic [5:0]        nbits;
	logic [LenW-1:0]   len_eff;

	assign advance = !valid_s1 || !cmd_full;
	assign full    = !advance;
	assign accept  = push && advance;

	// Classify the item and reduce exp-Golomb codes to the word w = v + 1.
	always_comb begin
		keep   = 1'b1;
		is_ue  = 1'b0;
		data   = value;
		len    = bit_count;
		pad    = 1'b0;
		sv_ext = {signed_value[30], signed_value};
		sv_neg = ~sv_ext + 32'd1;
		unique case (action_t'(action))
			ACT_RAW: begin
				len = (bit_count > MaxLen) ? MaxLen : bit_count;
			end
			ACT_UE: begin
				is_ue = 1'b1;
				data  = (value > UE_MAX) ? {32'd0, 32'hFFFF_FFFF}
				                         : {32'd0, value[31:0] + 32'd1};
			end
			ACT_SE: begin
				is_ue = 1'b1;
				if (!signed_value[30] && (signed_value != 31'sd0)) begin
					data = {32'd0, signed_value[30:0], 1'b0};
				end else begin
					data = {32'd0, sv_neg[30:0], 1'b1};
				end
			end
			ACT_NAL_START: begin
				data = {24'd0, START_CODE, 1'b0, ref_idc, nal_type};
				len  = NAL_HDR_LEN;
				pad  = 1'b1;
			end
			ACT_NAL_END: begin
				data = 64'd1;
				len  = 7'd1;
				pad  = 1'b1;
			end
			ACT_FLUSH: begin
				data = 64'd0;
				len  = 7'd0;
				pad  = 1'b1;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= accept && keep;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			is_ue_s1 <= is_ue;
			data_s1  <= data;
			len_s1   <= len;
			pad_s1   <= pad;
		end
	end

	// Exp-Golomb code of w with n significant bits is w written in 2n - 1 bits.
	always_comb begin
		nbits = 6'd0;
		for (int i = 0; i < 32; i++) begin
			if (data_s1[i]) begin
				nbits = 6'(i + 1);
			end
		end
		len_eff = is_ue_s1 ? (LenW'({nbits, 1'b0}) - 7'd1) : len_s1;
	end

	assign cmd.data = data_s1 << (7'd64 - len_eff);
	assign cmd.len  = len_eff;
	assign cmd.pad  = pad_s1;
	assign cmd_push = valid_s1 && !cmd_full;

endmodule

>>> rtl/egbw_cmd_fifo.sv
module egbw_cmd_fifo #(
	parameter int DEPTH = egbw_pkg::CmdFifoDepth
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr,
	input  egbw_pkg::cmd_t wdata,
	output logic           full,
	input  logic           rd,
	output egbw_pkg::cmd_t rdata,
	output logic           empty
);
	import egbw_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LastIdx = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FullCnt = CW'(DEPTH);

	cmd_t          mem_q [DEPTH];
	logic [AW-1:0] wptr_q;
	logic [AW-1:0] rptr_q;
	logic [CW-1:0] cnt_q;
	logic          do_wr;
	logic          do_rd;

	assign full  = (cnt_q == FullCnt);
	assign empty = (cnt_q == '0);
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;
	assign rdata = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= (wptr_q == LastIdx) ? '0 : wptr_q + AW'(1);
			end
			if (do_rd) begin
				rptr_q <= (rptr_q == LastIdx) ? '0 : rptr_q + AW'(1);
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

>>> rtl/egbw_back.sv
module egbw_back (
	input  logic           clk,
	input  logic           arst_n,
	input  egbw_pkg::cmd_t cmd,
	input  logic           cmd_empty,
	output logic           cmd_pop,
	output logic           empty,
	input  logic           pop,
	output logic [7:0]     out_byte,
	output logic           last_of_run
);
	import egbw_pkg::*;

	// Stream bits, left aligned; the top bits past the queued bytes are pending.
	logic [AccW-1:0] acc_q;
	logic [NbW-1:0]  nbytes_q;
	logic [2:0]      cnt_q;
	logic            ovalid_q;
	logic [7:0]      obyte_q;
	logic            olast_q;

	logic            emit;
	logic            can_load;
	logic [AccW-1:0] acc_sh;
	logic [AccW-1:0] merged;
	logic [LenW-1:0] total;
	logic [7:0]      total_up;
	logic [NbW-1:0]  nb;
	logic [2:0]      new_cnt;

	assign emit     = (nbytes_q != '0) && (!ovalid_q || pop);
	assign can_load = (nbytes_q == '0) || ((nbytes_q == NbW'(1)) && emit);
	assign cmd_pop  = can_load && !cmd_empty;

	always_comb begin
		acc_sh   = emit ? (acc_q << 8) : acc_q;
		merged   = {acc_sh[AccW-1 -: 8], 64'd0} | ({cmd.data, 8'd0} >> cnt_q);
		total    = LenW'(cnt_q) + cmd.len;
		total_up = {1'b0, total} + 8'd7;
		nb       = cmd.pad ? NbW'(total_up >> 3) : NbW'(total >> 3);
		new_cnt  = cmd.pad ? 3'd0 : total[2:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q    <= '0;
			nbytes_q <= '0;
			cnt_q    <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (cmd_pop) begin
				acc_q    <= merged;
				nbytes_q <= nb;
				cnt_q    <= new_cnt;
			end else if (emit) begin
				acc_q    <= acc_sh;
				nbytes_q <= nbytes_q - NbW'(1);
			end
			if (emit) begin
				ovalid_q <= 1'b1;
			end else if (pop) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			obyte_q <= acc_q[AccW-1 -: 8];
			olast_q <= (nbytes_q == NbW'(1));
		end
	end

	assign empty       = !ovalid_q;
	assign out_byte    = obyte_q;
	assign last_of_run = olast_q;

endmodule

>>> rtl/h264_exp_golomb_bit_writer.sv
// Flow: an accepted item is registered in the front stage, written to the command queue,
// loaded into the back-end accumulator, and its bytes leave through the output register.
// Throughput: the byte side emits one byte per cycle while pop keeps the output free; an
// item completes at most nine bytes, and the next one is loaded with its last byte.
// Reset: arst_n clears the pending partial byte, the command queue and the result.
module h264_exp_golomb_bit_writer #(
	parameter int MAX_RAW_BITS = egbw_pkg::MaxRawBitsDefault,
	parameter int CMD_DEPTH    = egbw_pkg::CmdFifoDepth
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [2:0]         action,
	input  logic [6:0]         bit_count,
	input  logic [63:0]        value,
	input  logic signed [30:0] signed_value,
	input  logic [4:0]         nal_type,
	input  logic [1:0]         ref_idc,
	output logic               empty,
	input  logic               pop,
	output logic [7:0]         out_byte,
	output logic               last_of_run
);
	import egbw_pkg::*;

	// The front end classifies each item and turns it into a normalized
	// command: a left-aligned run of bits plus an optional pad to the byte
	// boundary. Exp-Golomb codes are reduced to w = v + 1 written in 2n - 1
	// bits, so the back end never needs to know which action it came from.
	// Unused action codes are accepted and dropped here.
	cmd_t fq_wdata;
	cmd_t fq_rdata;
	logic fq_wr;
	logic fq_full;
	logic fq_rd;
	logic fq_empty;

	egbw_front #(
		.MAX_RAW_BITS(MAX_RAW_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.action      (action),
		.bit_count   (bit_count),
		.value       (value),
		.signed_value(signed_value),
		.nal_type    (nal_type),
		.ref_idc     (ref_idc),
		.cmd_push    (fq_wr),
		.cmd         (fq_wdata),
		.cmd_full    (fq_full)
	);

	// A short command queue lets the front keep accepting items while the
	// back end is still draining the bytes of an earlier one.
	egbw_cmd_fifo #(
		.DEPTH(CMD_DEPTH)
	) u_cmd_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.wr    (fq_wr),
		.wdata (fq_wdata),
		.full  (fq_full),
		.rd    (fq_rd),
		.rdata (fq_rdata),
		.empty (fq_empty)
	);

	// The back end merges each command behind the pending bits of the
	// unfinished byte and emits every completed byte through a single output
	// register. It takes the next command in the same cycle as the last
	// byte of the current one, and the final byte of each item is flagged.
	egbw_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (fq_rdata),
		.cmd_empty  (fq_empty),
		.cmd_pop    (fq_rd),
		.empty      (empty),
		.pop        (pop),
		.out_byte   (out_byte),
		.last_of_run(last_of_run)
	);

endmodule

>>> dv/h264_exp_golomb_bit_writer_test.sv
module h264_exp_golomb_bit_writer_test;
	timeunit 1ns;
	timeprecision 1ps;

	import egbw_pkg::*;

	// The action port is three bits wide, but the package names only six codes.
	// The block must ignore the two spare codes, so they get names here.
	localparam logic [2:0] ACT_SPARE6 = 3'd6;
	localparam logic [2:0] ACT_SPARE7 = 3'd7;

	localparam int RandItems   = 300;
	localparam int CycleLimit  = 100000;
	localparam int DrainCycles = 16;
	localparam int MaxShown    = 10;
	// A directed row with this byte count is checked against the predictor
	// instead of against a typed-in byte string.
	localparam int ByPredictor = -1;

	// One write command, in the same field order as the input ports.
	typedef struct packed {
		logic [2:0]         action;
		logic [6:0]         bit_count;
		logic [63:0]        value;
		logic signed [30:0] signed_value;
		logic [4:0]         nal_type;
		logic [1:0]         ref_idc;
	} cmd_item_t;

	// One expected byte of the output stream.
	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} stream_byte_t;

	// One row of the directed table. When n_typed is not ByPredictor, the
	// expected bytes are the low n_typed bytes of stream, first byte highest.
	typedef struct {
		cmd_item_t   cmd;
		int          n_typed;
		logic [71:0] stream;
	} dir_row_t;

	logic               clk          = 1'b0;
	logic               arst_n       = 1'b0;
	logic               push         = 1'b0;
	logic [2:0]         action       = ACT_RAW;
	logic [6:0]         bit_count    = '0;
	logic [63:0]        value        = '0;
	logic signed [30:0] signed_value = '0;
	logic [4:0]         nal_type     = '0;
	logic [1:0]         ref_idc      = '0;
	logic               pop          = 1'b0;
	logic               full;
	logic               empty;
	logic [7:0]         out_byte;
	logic               last_of_run;

	// Predictor state: the unfinished byte, right aligned, and its bit count.
	logic [6:0] pend_bits = '0;
	logic [2:0] pend_cnt  = '0;

	// Bytes completed by the item being predicted, and the expected stream.
	logic [7:0]   fresh_bytes[$];
	stream_byte_t stream_q[$];

	int tx_idle_pct = 8;
	int rx_idle_pct = 50;
	int err_cnt     = 0;
	int bytes_seen  = 0;
	int cycle_cnt   = 0;
	int spare_cnt   = 0;

	h264_exp_golomb_bit_writer dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.action       (action),
		.bit_count    (bit_count),
		.value        (value),
		.signed_value (signed_value),
		.nal_type     (nal_type),
		.ref_idc      (ref_idc),
		.empty        (empty),
		.pop          (pop),
		.out_byte     (out_byte),
		.last_of_run  (last_of_run)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Appends one bit behind the pending bits. The eighth bit completes a byte,
	// which goes to fresh_bytes, and the pending state starts over empty.
	task automatic shift_in_bit(input logic b);
		if (pend_cnt == 3'd7) begin
			fresh_bytes.push_back({pend_bits, b});
			pend_bits = '0;
			pend_cnt  = '0;
		end else begin
			pend_bits = {pend_bits[5:0], b};
			pend_cnt  = pend_cnt + 3'd1;
		end
	endtask

	// Appends the low n bits of v, most significant bit first.
	task automatic shift_in_bits(input logic [63:0] v, input int n);
		for (int i = n; i > 0; i--)
			shift_in_bit(v[i-1]);
	endtask

	// Zero bits up to the next byte boundary; nothing when already aligned.
	task automatic pad_to_byte();
		while (pend_cnt != 3'd0)
			shift_in_bit(1'b0);
	endtask

	// Unsigned exp-Golomb: w = v + 1 has n significant bits, and the code is
	// n - 1 zero bits followed by w. Values above the 32-bit code range clip.
	task automatic shift_in_ue(input logic [63:0] v);
		logic [63:0] w;
		int          n;
		w = (v > UE_MAX) ? UE_MAX + 64'd1 : v + 64'd1;
		n = 0;
		for (int i = 0; i < 64; i++)
			if (w[i])
				n = i + 1;
		shift_in_bits(64'd0, n - 1);
		shift_in_bits(w, n);
	endtask

	// Predicts the bytes that one accepted item completes, into fresh_bytes.
	task automatic pack_cmd(input cmd_item_t it);
		longint sv;
		int     cnt;
		fresh_bytes.delete();
		case (it.action)
			ACT_RAW: begin
				// A count above the raw limit is clipped; a zero count writes nothing.
				cnt = (it.bit_count > MaxRawBitsDefault) ? MaxRawBitsDefault : int'(it.bit_count);
				shift_in_bits(it.value, cnt);
			end
			ACT_UE: shift_in_ue(it.value);
			ACT_SE: begin
				// Positive values map to odd codes, zero and negatives to even ones.
				sv = longint'($signed(it.signed_value));
				if (sv > 0)
					shift_in_ue(64'(2 * sv - 1));
				else
					shift_in_ue(64'(-2 * sv));
			end
			ACT_NAL_START: begin
				// Start code, forbidden zero bit, ref_idc, type, then alignment.
				shift_in_bits(64'(START_CODE), 32);
				shift_in_bit(1'b0);
				shift_in_bits(64'(it.ref_idc), 2);
				shift_in_bits(64'(it.nal_type), 5);
				pad_to_byte();
			end
			ACT_NAL_END: begin
				// The stop bit, then zero padding.
				shift_in_bit(1'b1);
				pad_to_byte();
			end
			ACT_FLUSH: pad_to_byte();
			default: ;
		endcase
	endtask

	// Drives one item, waits for the block to take it, and then records the
	// bytes it should produce. The last of them carries the last_of_run flag.
	task automatic send_item(input cmd_item_t it, input int n_typed,
			input logic [71:0] typed_stream);
		while ($urandom_range(99) < tx_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push         <= 1'b1;
		action       <= it.action;
		bit_count    <= it.bit_count;
		value        <= it.value;
		signed_value <= it.signed_value;
		nal_type     <= it.nal_type;
		ref_idc      <= it.ref_idc;
		do
			@(posedge clk);
		while (full);
		pack_cmd(it);
		if (!(it.action <= ACT_FLUSH))
			spare_cnt++;
		// A typed-in row replaces the predicted bytes, while the predictor state
		// still advances so that later rows start from the right place.
		if (n_typed != ByPredictor) begin
			fresh_bytes.delete();
			for (int k = 0; k < n_typed; k++)
				fresh_bytes.push_back(typed_stream[8*(n_typed-1-k) +: 8]);
		end
		for (int k = 0; k < fresh_bytes.size(); k++)
			stream_q.push_back({fresh_bytes[k], k == fresh_bytes.size() - 1});
	endtask

	function automatic dir_row_t mk_row(input logic [2:0] act, input logic [6:0] cnt,
			input logic [63:0] val, input logic signed [30:0] sval, input logic [4:0] nt,
			input logic [1:0] ri, input int n_typed, input logic [71:0] stream);
		dir_row_t r;
		r.cmd     = {act, cnt, val, sval, nt, ri};
		r.n_typed = n_typed;
		r.stream  = stream;
		return r;
	endfunction

	// Random items are mostly well-formed commands with random content. Every
	// field is randomized first, so the fields that an action ignores toggle
	// too, and then the fields that matter are shaped toward useful ranges.
	function automatic cmd_item_t rand_item();
		cmd_item_t it;
		int        pick;
		it.action       = 3'($urandom_range(7));
		it.bit_count    = 7'($urandom);
		it.value        = {$urandom, $urandom};
		it.signed_value = 31'($urandom);
		it.nal_type     = 5'($urandom);
		it.ref_idc      = 2'($urandom);
		pick            = $urandom_range(99);
		if (pick < 30) begin
			// Raw bits: mostly legal counts; otherwise any 7-bit count, even zero or above the limit.
			it.action = ACT_RAW;
			if ($urandom_range(9) != 0)
				it.bit_count = 7'($urandom_range(64, 1));
			if ($urandom_range(3) == 0)
				it.value = 64'($urandom_range(255));
		end else if (pick < 55) begin
			// Unsigned codes from very short ones up to clipped 64-bit values.
			it.action = ACT_UE;
			case ($urandom_range(3))
				0: it.value = 64'($urandom_range(15));
				1: it.value = 64'($urandom_range(65535));
				2: it.value = {32'd0, $urandom};
				default: ;
			endcase
		end else if (pick < 75) begin
			it.action = ACT_SE;
			if ($urandom_range(1) == 0)
				it.signed_value = 31'(int'($urandom_range(40)) - 20);
		end else if (pick < 83) begin
			it.action = ACT_NAL_START;
		end else if (pick < 90) begin
			it.action = ACT_NAL_END;
		end else if (pick < 96) begin
			it.action = ACT_FLUSH;
		end else begin
			it.action = $urandom_range(1) ? ACT_SPARE7 : ACT_SPARE6;
		end
		return it;
	endfunction

	// Byte side: a byte leaves the block at an edge where pop is high and
	// empty is low. Both are sampled before the edge updates anything, and pop
	// is redrawn for the next edge according to the receiver's idle rate.
	always @(posedge clk) begin : byte_check
		stream_byte_t want;
		if (arst_n && pop && !empty) begin
			bytes_seen++;
			if (stream_q.size() == 0) begin
				err_cnt++;
				if (err_cnt <= MaxShown)
					$display("%0t ns: unexpected byte %02h last %0b", $time, out_byte,
						last_of_run);
			end else begin
				want = stream_q.pop_front();
				if (out_byte !== want.data || last_of_run !== want.last) begin
					err_cnt++;
					if (err_cnt <= MaxShown)
						$display("%0t ns: byte mismatch, expected %02h last %0b, got %02h last %0b",
							$time, want.data, want.last, out_byte, last_of_run);
				end
			end
		end
		pop <= arst_n && ($urandom_range(99) >= rx_idle_pct);
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CycleLimit) begin
			$display("Timed out after %0d cycles, %0d bytes still expected", cycle_cnt,
				stream_q.size());
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin : stimulus
		dir_row_t  rows[$];
		cmd_item_t it;
		int        n_rand;

		// Directed table. Rows with a byte string follow a known stream state,
		// so their output can be written down directly.
		// NAL start right after reset: start code, then 0 11 00101.
		rows.push_back(mk_row(ACT_NAL_START, 7'd0, 64'd0, 31'sd0, 5'd5, 2'd3,
			5, 72'h00_0000_0165));
		rows.push_back(mk_row(ACT_RAW, 7'd8, 64'hA5, 31'sd0, 5'd0, 2'd0, 1, 72'hA5));
		// Widest raw write of all ones.
		rows.push_back(mk_row(ACT_RAW, 7'd64, 64'hFFFF_FFFF_FFFF_FFFF, 31'sd0, 5'd0, 2'd0,
			8, 72'hFF_FFFF_FFFF_FFFF_FF));
		// A zero bit count writes nothing.
		rows.push_back(mk_row(ACT_RAW, 7'd0, 64'hFFFF_FFFF_FFFF_FFFF, 31'sd0, 5'd0, 2'd0,
			0, 72'h0));
		// A bit count above the limit is clipped to 64.
		rows.push_back(mk_row(ACT_RAW, 7'd127, 64'h0123_4567_89AB_CDEF, 31'sd0, 5'd0, 2'd0,
			8, 72'h01_2345_6789_ABCD_EF));
		// Unsigned zero is the single bit 1, which completes no byte.
		rows.push_back(mk_row(ACT_UE, 7'd0, 64'd0, 31'sd0, 5'd0, 2'd0, 0, 72'h0));
		rows.push_back(mk_row(ACT_FLUSH, 7'd0, 64'd0, 31'sd0, 5'd0, 2'd0, 1, 72'h80));
		// A huge unsigned value clips to the top code: 31 zeros and 32 ones,
		// which leaves seven ones pending.
		rows.push_back(mk_row(ACT_UE, 7'd0, 64'hFFFF_FFFF_FFFF_FFFF, 31'sd0, 5'd0, 2'd0,
			7, 72'h00_0000_01FF_FFFF));
		// The stop bit completes that byte, so no padding follows.
		rows.push_back(mk_row(ACT_NAL_END, 7'd0, 64'd0, 31'sd0, 5'd0, 2'd0, 1, 72'hFF));
		// Spare action codes write nothing, whatever the other fields hold.
		rows.push_back(mk_row(ACT_SPARE6, 7'd8, 64'hFFFF_FFFF_FFFF_FFFF, 31'sh7FFF_FFFF,
			5'd31, 2'd3, 0, 72'h0));
		rows.push_back(mk_row(ACT_SPARE7, 7'd64, 64'hFFFF_FFFF_FFFF_FFFF, 31'sh7FFF_FFFF,
			5'd31, 2'd3, 0, 72'h0));
		rows.push_back(mk_row(ACT_UE, 7'd0, UE_MAX, 31'sd0, 5'd0, 2'd0, ByPredictor, 72'h0));
		rows.push_back(mk_row(ACT_UE, 7'd0, UE_MAX + 64'd1, 31'sd0, 5'd0, 2'd0,
			ByPredictor, 72'h0));
		// Signed extremes and the values around zero.
		rows.push_back(mk_row(ACT_SE, 7'd0, 64'd0, 31'sh3FFF_FFFF, 5'd0, 2'd0,
			ByPredictor, 72'h0));
		rows.push_back(mk_row(ACT_SE, 7'd0, 64'd0, 31'sh4000_0000, 5'd0, 2'd0,
			ByPredictor, 72'h0));
		rows.push_back(mk_row(ACT_SE, 7'd0, 64'd0, 31'sd0, 5'd0, 2'd0, ByPredictor, 72'h0));
		rows.push_back(mk_row(ACT_SE, 7'd0, 64'd0, 31'sh7FFF_FFFF, 5'd0, 2'd0,
			ByPredictor, 72'h0));
		rows.push_back(mk_row(ACT_SE, 7'd0, 64'd0, 31'sd1, 5'd0, 2'd0, ByPredictor, 72'h0));
		rows.push_back(mk_row(ACT_RAW, 7'd1, 64'd1, 31'sd0, 5'd0, 2'd0, ByPredictor, 72'h0));
		rows.push_back(mk_row(ACT_RAW, 7'd63, 64'hFFFF_0000_AAAA_5555, 31'sd0, 5'd0, 2'd0,
			ByPredictor, 72'h0));
		rows.push_back(mk_row(ACT_FLUSH, 7'd0, 64'd0, 31'sd0, 5'd0, 2'd0, ByPredictor, 72'h0));
		// Flush with nothing pending writes nothing.
		rows.push_back(mk_row(ACT_FLUSH, 7'd0, 64'd0, 31'sd0, 5'd0, 2'd0, 0, 72'h0));
		rows.push_back(mk_row(ACT_NAL_START, 7'd0, 64'd0, 31'sd0, 5'd0, 2'd0,
			5, 72'h00_0000_0100));
		// NAL start behind three pending bits, with the largest type.
		rows.push_back(mk_row(ACT_RAW, 7'd3, 64'd5, 31'sd0, 5'd0, 2'd0, ByPredictor, 72'h0));
		rows.push_back(mk_row(ACT_NAL_START, 7'd0, 64'd0, 31'sd0, 5'd31, 2'd2,
			ByPredictor, 72'h0));
		rows.push_back(mk_row(ACT_NAL_END, 7'd0, 64'd0, 31'sd0, 5'd0, 2'd0, 1, 72'h80));
		rows.push_back(mk_row(ACT_UE, 7'd0, 64'd5, 31'sd0, 5'd0, 2'd0, ByPredictor, 72'h0));

		// Reset is held low from the start and released on a clock edge.
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// The directed part runs in the first idling phase: a sender that
		// rarely pauses and a receiver that stalls half of the time.
		foreach (rows[i])
			send_item(rows[i].cmd, rows[i].n_typed, rows[i].stream);

		// Random part in three phases: the same idling, then the roles swapped,
		// and finally full speed on both sides. Spare action codes do not count.
		n_rand = 0;
		while (n_rand < RandItems) begin
			if (n_rand == RandItems / 3) begin
				tx_idle_pct = 50;
				rx_idle_pct = 8;
			end else if (n_rand == 2 * RandItems / 3) begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			it = rand_item();
			send_item(it, ByPredictor, 72'h0);
			if (it.action <= ACT_FLUSH)
				n_rand++;
		end
		push <= 1'b0;

		// Wait for every expected byte, then for a drain period so that a stray
		// byte from an item that should have produced none still shows up.
		while (stream_q.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);

		$display("Sent %0d directed and %0d random items (%0d with spare action codes).",
			rows.size(), n_rand, spare_cnt);
		$display("Checked %0d stream bytes over three idling phases; %0d errors.",
			bytes_seen, err_cnt);
		if (err_cnt == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

>>> h264_exp_golomb_bit_writer.f
rtl/egbw_pkg.sv
rtl/egbw_front.sv
rtl/egbw_cmd_fifo.sv
rtl/egbw_back.sv
rtl/h264_exp_golomb_bit_writer.sv
dv/h264_exp_golomb_bit_writer_test.sv
